[design/assert_macros.svh]
// Assertion macros shared by the aging page replacement RTL.
// No dependencies; the checks drop out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define APR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define APR_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define APR_ASSERT(label, clk, rst_n, prop, msg)
`define APR_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

[design/apr_pkg.sv]
// Package for the aging page replacement block: defaults, port widths, FSM type.
// No dependencies.
`default_nettype none
package apr_pkg;

    localparam int NUM_FRAMES_DEF = 16;
    localparam int AGE_BITS_DEF   = 32;
    localparam int PAGE_BITS_DEF  = 16;

    localparam int PAGE_PORT_W  = 16;
    localparam int INDEX_PORT_W = 4;
    localparam int CFG_W        = 5;
    localparam int TOTAL_W      = 32;

    localparam logic [CFG_W-1:0] FRAMES_RESET = 5'd16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PLACE
    } state_t;

endpackage
`default_nettype wire

[design/apr_cell.sv]
// One page frame of the replacement table: page, valid mark and aging counter.
// Folds its frame into the search record passed along the chain. Uses apr_pkg defaults.
`default_nettype none
module apr_cell #(
    parameter int NUM_FRAMES = apr_pkg::NUM_FRAMES_DEF,
    parameter int AGE_BITS   = apr_pkg::AGE_BITS_DEF,
    parameter int PAGE_BITS  = apr_pkg::PAGE_BITS_DEF,
    parameter int INDEX      = 0,
    localparam int IDX_W     = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1,
    localparam int CNT_W     = $clog2(NUM_FRAMES + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [CNT_W-1:0] n_active,
    input  wire logic             upd_en,
    input  wire logic [IDX_W-1:0] upd_slot,
    input  wire logic             upd_place,
    input  wire logic [PAGE_BITS-1:0] upd_page,
    input  wire logic             rin_valid,
    input  wire logic [PAGE_BITS-1:0] rin_page,
    input  wire logic             rin_hit,
    input  wire logic [IDX_W-1:0] rin_hit_idx,
    input  wire logic             rin_empty,
    input  wire logic [IDX_W-1:0] rin_empty_idx,
    input  wire logic [AGE_BITS-1:0] rin_min_age,
    input  wire logic [IDX_W-1:0] rin_min_idx,
    input  wire logic [PAGE_BITS-1:0] rin_min_page,
    output logic                  rout_valid,
    output logic [PAGE_BITS-1:0]  rout_page,
    output logic                  rout_hit,
    output logic [IDX_W-1:0]      rout_hit_idx,
    output logic                  rout_empty,
    output logic [IDX_W-1:0]      rout_empty_idx,
    output logic [AGE_BITS-1:0]   rout_min_age,
    output logic [IDX_W-1:0]      rout_min_idx,
    output logic [PAGE_BITS-1:0]  rout_min_page
);

    localparam logic [IDX_W-1:0] ME    = IDX_W'(INDEX);
    localparam logic [CNT_W-1:0] ME_N  = CNT_W'(INDEX);
    localparam bit               FIRST = (INDEX == 0);

    typedef struct packed {
        logic                 valid;
        logic [PAGE_BITS-1:0] page;
        logic                 hit;
        logic [IDX_W-1:0]     hit_idx;
        logic                 empty;
        logic [IDX_W-1:0]     empty_idx;
        logic [AGE_BITS-1:0]  min_age;
        logic [IDX_W-1:0]     min_idx;
        logic [PAGE_BITS-1:0] min_page;
    } rec_t;

    logic [PAGE_BITS-1:0] page_reg;
    logic                 valid_reg;
    logic [AGE_BITS-1:0]  age_reg;
    rec_t                 rec_reg;
    rec_t                 rec_next;
    logic                 active;

    assign active = (ME_N < n_active);

    always_comb
    begin
        rec_next = '{valid: rin_valid, page: rin_page, hit: rin_hit,
                     hit_idx: rin_hit_idx, empty: rin_empty,
                     empty_idx: rin_empty_idx, min_age: rin_min_age,
                     min_idx: rin_min_idx, min_page: rin_min_page};
        if (active)
        begin
            if (!rin_hit && valid_reg && (page_reg == rin_page))
            begin
                rec_next.hit     = 1'b1;
                rec_next.hit_idx = ME;
            end
            if (!rin_empty && !valid_reg)
            begin
                rec_next.empty     = 1'b1;
                rec_next.empty_idx = ME;
            end
            // frame 0 seeds the minimum; strict compare keeps the lowest index on ties
            if (FIRST || (age_reg < rin_min_age))
            begin
                rec_next.min_age  = age_reg;
                rec_next.min_idx  = ME;
                rec_next.min_page = page_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_reg <= '0;
        end
        else
        begin
            rec_reg <= rec_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_reg  <= '0;
            valid_reg <= 1'b0;
            age_reg   <= '0;
        end
        else if (upd_en && active)
        begin
            age_reg <= {(upd_slot == ME), age_reg[AGE_BITS-1:1]};
            if (upd_place && (upd_slot == ME))
            begin
                page_reg  <= upd_page;
                valid_reg <= 1'b1;
            end
        end
    end

    assign rout_valid     = rec_reg.valid;
    assign rout_page      = rec_reg.page;
    assign rout_hit       = rec_reg.hit;
    assign rout_hit_idx   = rec_reg.hit_idx;
    assign rout_empty     = rec_reg.empty;
    assign rout_empty_idx = rec_reg.empty_idx;
    assign rout_min_age   = rec_reg.min_age;
    assign rout_min_idx   = rec_reg.min_idx;
    assign rout_min_page  = rec_reg.min_page;

endmodule
`default_nettype wire

[design/aging_page_replacement.sv]
// The search record walks the chain of frame cells one cell per cycle, then the
// decision is registered in the scan state, then the place step places and ages all
// active frames. A new request is taken only in the idle state, after the last is placed.
// A stalled result holds the block in the place step.
// Reset: all frames empty, ages and totals zero, frames_in_use back to 16.
// Top level: frame cell chain (apr_cell) and controller; uses apr_pkg, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module aging_page_replacement #(
    parameter int NUM_FRAMES = apr_pkg::NUM_FRAMES_DEF,
    parameter int AGE_BITS   = apr_pkg::AGE_BITS_DEF,
    parameter int PAGE_BITS  = apr_pkg::PAGE_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              frames_in_use_we,
    input  wire logic [apr_pkg::CFG_W-1:0]         frames_in_use,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [apr_pkg::PAGE_PORT_W-1:0]   page_id,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   hit,
    output logic [apr_pkg::INDEX_PORT_W-1:0]       frame_index,
    output logic                                   evicted_valid,
    output logic [apr_pkg::PAGE_PORT_W-1:0]        evicted_page,
    output logic [apr_pkg::TOTAL_W-1:0]            hit_total,
    output logic [apr_pkg::TOTAL_W-1:0]            miss_total
);

    localparam int IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int CNT_W = $clog2(NUM_FRAMES + 1);
    localparam int CMP_W = (CNT_W > apr_pkg::CFG_W) ? CNT_W : apr_pkg::CFG_W;

    typedef struct packed {
        logic                 valid;
        logic [PAGE_BITS-1:0] page;
        logic                 hit;
        logic [IDX_W-1:0]     hit_idx;
        logic                 empty;
        logic [IDX_W-1:0]     empty_idx;
        logic [AGE_BITS-1:0]  min_age;
        logic [IDX_W-1:0]     min_idx;
        logic [PAGE_BITS-1:0] min_page;
    } rec_t;

    typedef struct packed {
        logic                 en;
        logic [IDX_W-1:0]     slot;
        logic                 place;
        logic [PAGE_BITS-1:0] page;
    } upd_t;

    apr_pkg::state_t state_reg, state_next;

    logic [apr_pkg::CFG_W-1:0] frames_in_use_reg;
    logic [CMP_W-1:0]          cfg_wide;
    logic [CMP_W-1:0]          n_wide;
    logic [CNT_W-1:0]          n_active;

    rec_t chain [NUM_FRAMES+1];
    rec_t tail;
    upd_t upd;

    logic accept, load_dec, fire;

    logic                 dec_hit_next, dec_ev_next, dec_place_next;
    logic [IDX_W-1:0]     dec_slot_next;
    logic [PAGE_BITS-1:0] dec_ev_page_next;
    logic                 dec_hit_reg, dec_ev_reg, dec_place_reg;
    logic [IDX_W-1:0]     dec_slot_reg;
    logic [PAGE_BITS-1:0] dec_ev_page_reg, dec_page_reg;

    logic                               out_valid_reg, hit_reg, evicted_valid_reg;
    logic [apr_pkg::INDEX_PORT_W-1:0]   frame_index_reg;
    logic [apr_pkg::PAGE_PORT_W-1:0]    evicted_page_reg;
    logic [apr_pkg::TOTAL_W-1:0]        hits_seen_reg, misses_seen_reg;

    // configuration register and clamped frame count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_in_use_reg <= apr_pkg::FRAMES_RESET;
        end
        else if (frames_in_use_we)
        begin
            frames_in_use_reg <= frames_in_use;
        end
    end

    always_comb
    begin
        cfg_wide = CMP_W'(frames_in_use_reg);
        if (cfg_wide == '0)
        begin
            n_wide = CMP_W'(1);
        end
        else if (cfg_wide > CMP_W'(NUM_FRAMES))
        begin
            n_wide = CMP_W'(NUM_FRAMES);
        end
        else
        begin
            n_wide = cfg_wide;
        end
        n_active = CNT_W'(n_wide);
    end

    // record injected into cell 0 on the accepting edge
    always_comb
    begin
        chain[0]       = '0;
        chain[0].valid = accept;
        chain[0].page  = PAGE_BITS'(page_id);
        chain[0].min_age = '1;
    end

    assign upd = '{en: fire, slot: dec_slot_reg, place: dec_place_reg,
                   page: dec_page_reg};

    for (genvar k = 0; k < NUM_FRAMES; k++)
    begin : g_cell
        apr_cell #(
            .NUM_FRAMES (NUM_FRAMES),
            .AGE_BITS   (AGE_BITS),
            .PAGE_BITS  (PAGE_BITS),
            .INDEX      (k)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .n_active       (n_active),
            .upd_en         (upd.en),
            .upd_slot       (upd.slot),
            .upd_place      (upd.place),
            .upd_page       (upd.page),
            .rin_valid      (chain[k].valid),
            .rin_page       (chain[k].page),
            .rin_hit        (chain[k].hit),
            .rin_hit_idx    (chain[k].hit_idx),
            .rin_empty      (chain[k].empty),
            .rin_empty_idx  (chain[k].empty_idx),
            .rin_min_age    (chain[k].min_age),
            .rin_min_idx    (chain[k].min_idx),
            .rin_min_page   (chain[k].min_page),
            .rout_valid     (chain[k+1].valid),
            .rout_page      (chain[k+1].page),
            .rout_hit       (chain[k+1].hit),
            .rout_hit_idx   (chain[k+1].hit_idx),
            .rout_empty     (chain[k+1].empty),
            .rout_empty_idx (chain[k+1].empty_idx),
            .rout_min_age   (chain[k+1].min_age),
            .rout_min_idx   (chain[k+1].min_idx),
            .rout_min_page  (chain[k+1].min_page)
        );
    end

    assign tail = chain[NUM_FRAMES];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            apr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = apr_pkg::ST_SCAN;
                end
            end
            apr_pkg::ST_SCAN:
            begin
                if (tail.valid)
                begin
                    state_next = apr_pkg::ST_PLACE;
                end
            end
            apr_pkg::ST_PLACE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = apr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = apr_pkg::ST_IDLE;
            end
        endcase
    end

    // FSM outputs
    always_comb
    begin
        in_ready = 1'b0;
        load_dec = 1'b0;
        fire     = 1'b0;
        case (state_reg)
            apr_pkg::ST_IDLE:  in_ready = 1'b1;
            apr_pkg::ST_SCAN:  load_dec = tail.valid;
            apr_pkg::ST_PLACE: fire     = !out_valid_reg || out_ready;
            default:           in_ready = 1'b0;
        endcase
    end

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= apr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // hit first, then first empty frame, else the oldest frame is the victim
    always_comb
    begin
        dec_hit_next     = tail.hit;
        dec_ev_next      = 1'b0;
        dec_ev_page_next = '0;
        if (tail.hit)
        begin
            dec_slot_next  = tail.hit_idx;
            dec_place_next = 1'b0;
        end
        else if (tail.empty)
        begin
            dec_slot_next  = tail.empty_idx;
            dec_place_next = 1'b1;
        end
        else
        begin
            dec_slot_next    = tail.min_idx;
            dec_place_next   = 1'b1;
            dec_ev_next      = 1'b1;
            dec_ev_page_next = tail.min_page;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_dec)
        begin
            dec_hit_reg     <= dec_hit_next;
            dec_ev_reg      <= dec_ev_next;
            dec_place_reg   <= dec_place_next;
            dec_slot_reg    <= dec_slot_next;
            dec_ev_page_reg <= dec_ev_page_next;
            dec_page_reg    <= tail.page;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            hits_seen_reg   <= '0;
            misses_seen_reg <= '0;
        end
        else
        begin
            if (fire)
            begin
                out_valid_reg <= 1'b1;
                if (dec_hit_reg)
                begin
                    hits_seen_reg <= hits_seen_reg + 32'd1;
                end
                else
                begin
                    misses_seen_reg <= misses_seen_reg + 32'd1;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            hit_reg           <= dec_hit_reg;
            frame_index_reg   <= apr_pkg::INDEX_PORT_W'(dec_slot_reg);
            evicted_valid_reg <= dec_ev_reg;
            evicted_page_reg  <= apr_pkg::PAGE_PORT_W'(dec_ev_page_reg);
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign frame_index   = frame_index_reg;
    assign evicted_valid = evicted_valid_reg;
    assign evicted_page  = evicted_page_reg;
    assign hit_total     = hits_seen_reg;
    assign miss_total    = misses_seen_reg;

    `APR_ASSERT(a_fire_shows, clk, rst_n, fire |=> out_valid_reg,
                "placed request gave no result")
    `APR_NEVER(a_tail_scan, clk, rst_n, tail.valid && (state_reg != apr_pkg::ST_SCAN),
               "search record left chain outside scan")
    `APR_NEVER(a_hit_evict, clk, rst_n, out_valid_reg && hit_reg && evicted_valid_reg,
               "hit reported with an eviction")
    `APR_ASSERT(a_one_count, clk, rst_n,
                fire |=> (32'(hits_seen_reg + misses_seen_reg) ==
                          32'($past(hits_seen_reg) + $past(misses_seen_reg) + 32'd1)),
                "totals did not advance by one")
    `APR_NEVER(a_chain_busy, clk, rst_n, accept && (chain[1].valid || tail.valid),
               "request taken while chain busy")

endmodule
`default_nettype wire
